// ----- rtl/core/wavetable_oscillator_top_defines.svh -----
// ---------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shared concurrent assertion forms for the oscillator RTL.
// ---------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_TOP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WTO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/wto_pkg.sv -----
// ---------------------------------------------------------------------------
// Wavetable oscillator package
// Default sizes, field widths, codes and control types of the oscillator.
// ---------------------------------------------------------------------------
package wto_pkg;

	localparam int TABLE_SIZE_DEF   = 2048;
	localparam int NUM_TABLES_DEF   = 4;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int PHASE_W = 32;
	localparam int FRAC_W  = 16;
	localparam int DATA_W  = 16;
	localparam int AMP_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = 49;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WAVEFORM = 2'd0,
		CFG_NOISE    = 2'd1,
		CFG_GAIN     = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_INTERP,
		ST_SUM,
		ST_SCALE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_AMP_GAIN,
		MUL_INTERP,
		MUL_SCALE
	} mul_sel_t;

	typedef struct packed {
		logic     rd_en;
		logic     rd_next;
		logic     cap_a;
		logic     cap_ag;
		logic     cap_s;
		logic     load_out;
		mul_sel_t mul_sel;
	} ctrl_t;

endpackage

// ----- rtl/core/wto_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/wto_mul.sv -----
// ---------------------------------------------------------------------------
// Wavetable oscillator shared multiplier
// Signed by unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module wto_mul (
	input  logic                                clk,
	input  logic signed [wto_pkg::MUL_A_W-1:0] op_a,
	input  logic        [wto_pkg::MUL_B_W-1:0] op_b,
	output logic signed [wto_pkg::MUL_P_W-1:0] prod_q
);

	logic signed [wto_pkg::MUL_A_W+wto_pkg::MUL_B_W:0] full;

	assign full = op_a * $signed({1'b0, op_b});

	always_ff @(posedge clk) begin
		prod_q <= full[wto_pkg::MUL_P_W-1:0];
	end

endmodule

// ----- rtl/core/wto_ctrl.sv -----
// ---------------------------------------------------------------------------
// Wavetable oscillator sequencer
// Steps one tick word through table reads, interpolation and scaling.
// ---------------------------------------------------------------------------
module wto_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           out_free,
	output logic           idle,
	output wto_pkg::ctrl_t ctrl
);

	wto_pkg::state_t state_q;
	wto_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wto_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wto_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = wto_pkg::ST_RD_A;
				end
			end
			wto_pkg::ST_RD_A:   state_nxt = wto_pkg::ST_RD_B;
			wto_pkg::ST_RD_B:   state_nxt = wto_pkg::ST_INTERP;
			wto_pkg::ST_INTERP: state_nxt = wto_pkg::ST_SUM;
			wto_pkg::ST_SUM:    state_nxt = wto_pkg::ST_SCALE;
			wto_pkg::ST_SCALE:  state_nxt = wto_pkg::ST_OUT;
			wto_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = wto_pkg::ST_IDLE;
				end
			end
			default: state_nxt = wto_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = wto_pkg::MUL_AMP_GAIN;
		idle = 1'b0;
		case (state_q)
			wto_pkg::ST_IDLE: begin
				idle = 1'b1;
			end
			wto_pkg::ST_RD_A: begin
				ctrl.rd_en = 1'b1;
			end
			wto_pkg::ST_RD_B: begin
				ctrl.rd_en   = 1'b1;
				ctrl.rd_next = 1'b1;
				ctrl.cap_a   = 1'b1;
				ctrl.cap_ag  = 1'b1;
			end
			wto_pkg::ST_INTERP: begin
				ctrl.mul_sel = wto_pkg::MUL_INTERP;
			end
			wto_pkg::ST_SUM: begin
				ctrl.cap_s = 1'b1;
			end
			wto_pkg::ST_SCALE: begin
				ctrl.mul_sel = wto_pkg::MUL_SCALE;
			end
			wto_pkg::ST_OUT: begin
				ctrl.mul_sel  = wto_pkg::MUL_SCALE;
				ctrl.load_out = out_free;
			end
			default: begin
				idle = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/core/wavetable_oscillator_top.sv -----
// ---------------------------------------------------------------------------
// Wavetable oscillator top level
// Phase-accumulator oscillator with loadable, linearly interpolated tables.
// ---------------------------------------------------------------------------
// Words enter on the req channel (valid/ready). A write word stores one table
// entry in the cycle it is accepted and produces no result. A tick word
// produces one sample on the rsp channel (valid/ready). After a tick is
// accepted, the sequencer steps through two reads of the table memory, an
// interpolation product, a sum, a scaling product and the rounding into the
// output register. req_ready returns in the same cycle as the sample becomes
// valid, so no word is accepted before the sample is loaded; the single
// shared multiplier and the registered memory read make the steps sequential.
// The output register holds a finished sample while the receiver stalls;
// the next word is accepted meanwhile, and a following tick waits in its
// last step until the register is free.
// Reset clears the phase, the noise counter, the waveform and noise selects
// and sets the gain to its reset value; table contents are undefined until
// written and no clearing pass is run.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module wavetable_oscillator_top #(
	parameter int TABLE_SIZE   = wto_pkg::TABLE_SIZE_DEF,
	parameter int NUM_TABLES   = wto_pkg::NUM_TABLES_DEF,
	parameter int SAMPLE_WIDTH = wto_pkg::SAMPLE_WIDTH_DEF,
	localparam int SEL_W       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
	localparam int TADDR_W     = $clog2(TABLE_SIZE + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wto_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wto_pkg::GAIN_W-1:0]          cfg_data,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                opcode,
	input  logic [wto_pkg::PHASE_W-1:0]         phase_step,
	input  logic [wto_pkg::AMP_W-1:0]           amplitude,
	input  logic [SEL_W-1:0]                    table_select,
	input  logic [TADDR_W-1:0]                  table_addr,
	input  logic signed [wto_pkg::DATA_W-1:0]   table_data,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped
);

	`include "wavetable_oscillator_top_defines.svh"

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int DEPTH   = NUM_TABLES * (TABLE_SIZE + 1);
	localparam int RAM_AW  = $clog2(DEPTH);
	localparam int SHIFT   = 43 - SAMPLE_WIDTH;
	localparam int QW      = wto_pkg::MUL_P_W - SHIFT;
	localparam int DW      = wto_pkg::DATA_W;
	localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [QW-1:0] Q_LO = ~Q_HI;
	localparam logic signed [wto_pkg::MUL_P_W-1:0] OUT_RND =
		wto_pkg::MUL_P_W'(64'sd1 <<< (SHIFT - 1));
	localparam logic signed [wto_pkg::MUL_P_W-1:0] FRAC_RND =
		wto_pkg::MUL_P_W'(64'sd1 <<< (wto_pkg::FRAC_W - 1));

	logic [SEL_W-1:0]               wave_sel_q;
	logic                           noise_q;
	logic [wto_pkg::GAIN_W-1:0]     gain_q;
	logic [wto_pkg::PHASE_W-1:0]    phase_q;
	logic [IDX_W-1:0]               noise_cnt_q;

	logic [IDX_W-1:0]               idx_q;
	logic [wto_pkg::FRAC_W-1:0]     frac_q;
	logic [wto_pkg::AMP_W-1:0]      amp_q;
	logic                           sel_ok_q;
	logic signed [DW-1:0]           a_q;
	logic signed [DW-1:0]           s_q;
	logic [wto_pkg::MUL_B_W-1:0]    ag_q;

	logic                           req_fire;
	logic                           tick_fire;
	logic                           wr_en;
	logic [RAM_AW-1:0]              waddr;
	logic [RAM_AW-1:0]              raddr;
	logic [DW-1:0]                  rdata;
	logic                           out_free;
	logic                           idle;
	wto_pkg::ctrl_t                 ctrl;

	logic signed [wto_pkg::MUL_A_W-1:0] mul_a;
	logic        [wto_pkg::MUL_B_W-1:0] mul_b;
	logic signed [wto_pkg::MUL_P_W-1:0] prod;
	logic signed [wto_pkg::MUL_P_W-1:0] frac_rnd;
	logic signed [DW:0]                 s_sum;
	logic signed [wto_pkg::MUL_P_W-1:0] out_rnd;
	logic signed [QW-1:0]               q;

	assign req_ready = idle;
	assign req_fire  = req_valid && req_ready;
	assign tick_fire = req_fire && (wto_pkg::opcode_t'(opcode) == wto_pkg::OP_TICK);
	assign out_free  = !rsp_valid || rsp_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel_q <= '0;
			noise_q    <= 1'b0;
			gain_q     <= wto_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (wto_pkg::cfg_reg_t'(cfg_index))
				wto_pkg::CFG_WAVEFORM: wave_sel_q <= cfg_data[SEL_W-1:0];
				wto_pkg::CFG_NOISE:    noise_q    <= cfg_data[0];
				wto_pkg::CFG_GAIN:     gain_q     <= cfg_data;
				default:               gain_q     <= gain_q;
			endcase
		end
	end

	// Phase advances when a tick is accepted; the noise counter only in noise mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			noise_cnt_q <= '0;
		end else if (tick_fire) begin
			phase_q <= phase_q + phase_step;
			if (noise_q) begin
				noise_cnt_q <= noise_cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			idx_q    <= noise_q ? noise_cnt_q : phase_q[wto_pkg::PHASE_W-1 -: IDX_W];
			frac_q   <= phase_q[wto_pkg::PHASE_W-1-IDX_W -: wto_pkg::FRAC_W];
			amp_q    <= amplitude;
			sel_ok_q <= (wave_sel_q < NUM_TABLES);
		end
		if (ctrl.cap_a) begin
			a_q <= rdata;
		end
		if (ctrl.cap_ag) begin
			ag_q <= prod[wto_pkg::MUL_B_W-1:0];
		end
		if (ctrl.cap_s) begin
			if (!sel_ok_q) begin
				s_q <= '0;
			end else if (noise_q) begin
				s_q <= a_q;
			end else begin
				s_q <= s_sum[DW-1:0];
			end
		end
	end

	// Table addressing: table * (TABLE_SIZE + 1) + entry, as a shift and adds.
	assign wr_en = req_fire && (wto_pkg::opcode_t'(opcode) == wto_pkg::OP_WRITE)
		&& (table_select < NUM_TABLES) && (table_addr <= TABLE_SIZE);
	assign waddr = RAM_AW'({table_select, {IDX_W{1'b0}}}) + RAM_AW'(table_select)
		+ RAM_AW'(table_addr);
	assign raddr = RAM_AW'({wave_sel_q, {IDX_W{1'b0}}}) + RAM_AW'(wave_sel_q)
		+ RAM_AW'(idx_q) + RAM_AW'(ctrl.rd_next);

	wto_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(table_data),
		.re   (ctrl.rd_en && sel_ok_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		case (ctrl.mul_sel)
			wto_pkg::MUL_INTERP: begin
				mul_a = $signed({rdata[DW-1], rdata}) - $signed({a_q[DW-1], a_q});
				mul_b = wto_pkg::MUL_B_W'(frac_q);
			end
			wto_pkg::MUL_SCALE: begin
				mul_a = $signed({s_q[DW-1], s_q});
				mul_b = ag_q;
			end
			default: begin
				mul_a = $signed({1'b0, amp_q});
				mul_b = wto_pkg::MUL_B_W'(gain_q);
			end
		endcase
	end

	wto_mul u_mul (
		.clk   (clk),
		.op_a  (mul_a),
		.op_b  (mul_b),
		.prod_q(prod)
	);

	// Interpolated sample: a + round((b - a) * frac / 2^16), ties upward.
	assign frac_rnd = prod + FRAC_RND;
	assign s_sum    = $signed({a_q[DW-1], a_q})
		+ $signed(frac_rnd[wto_pkg::FRAC_W+DW:wto_pkg::FRAC_W]);

	// Output scaling with rounding and saturation.
	assign out_rnd = prod + OUT_RND;
	assign q       = out_rnd[wto_pkg::MUL_P_W-1:SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (ctrl.load_out) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			if (q > Q_HI) begin
				sample_out <= Q_HI[SAMPLE_WIDTH-1:0];
				clipped    <= 1'b1;
			end else if (q < Q_LO) begin
				sample_out <= Q_LO[SAMPLE_WIDTH-1:0];
				clipped    <= 1'b1;
			end else begin
				sample_out <= q[SAMPLE_WIDTH-1:0];
				clipped    <= 1'b0;
			end
		end
	end

	wto_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (tick_fire),
		.out_free(out_free),
		.idle    (idle),
		.ctrl    (ctrl)
	);

	`WTO_ASSERT_NEXT(a_write_keeps_phase, req_fire && !tick_fire, $stable(phase_q) && $stable(noise_cnt_q), "write word changed the phase or the noise counter")
	`WTO_ASSERT_NEXT(a_tick_advances_phase, tick_fire, phase_q == $past(phase_q) + $past(phase_step), "phase did not advance by the step")
	`WTO_ASSERT_NEXT(a_counter_only_noise, !(tick_fire && noise_q), $stable(noise_cnt_q), "noise counter moved without a noise tick")
	`WTO_ASSERT_NOW(a_no_overwrite, ctrl.load_out, !rsp_valid || rsp_ready, "output register overwritten while stalled")

endmodule
